// ----- hw/rtl/fcs_pkg.sv -----
// ----------------------------------------------------------------------------
// fcs_pkg
// Shared types, constants and modulo-255 helpers for the LSA Fletcher
// checksum engine.
// ----------------------------------------------------------------------------
package fcs_pkg;

    // Fletcher modulus and LSA layout (1-based byte positions)
    localparam int unsigned ModBase     = 255;
    localparam int unsigned PosCap      = 19;
    localparam int unsigned AgeBytes    = 2;
    localparam int unsigned CksumPosHi  = 17;
    localparam int unsigned CksumPosLo  = 18;
    localparam int unsigned LenOffsetX  = 17;
    localparam int unsigned LenOffsetY  = 16;

    localparam int unsigned PosWidth    = 5;

    // Finished advertisement handed from the front to the back
    typedef struct packed {
        logic [7:0] gen_a;
        logic [7:0] gen_b;
        logic [7:0] length;
        logic       ok;
    } fcs_rec_t;

    // Sum of two residues; valid while a + b < 2 * 255
    function automatic logic [7:0] add_mod255(input logic [7:0] a, input logic [7:0] b);
        logic [8:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= 9'(ModBase))
            s = s - 9'(ModBase);
        return s[7:0];
    endfunction

    // Reduce a product of two residues: 256 is congruent to 1 modulo 255
    function automatic logic [7:0] fold_mod255(input logic [15:0] p);
        return add_mod255(p[15:8], p[7:0]);
    endfunction

endpackage

// ----- hw/rtl/fcs_front.sv -----
// ----------------------------------------------------------------------------
// fcs_front
// Byte accumulator: tracks position and length, runs the generate and verify
// Fletcher sums, and posts one record per advertisement on its last byte.
// ----------------------------------------------------------------------------
module fcs_front
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              byte_valid,
    output logic              byte_ready,
    input  logic [7:0]        byte_data,
    input  logic              byte_last,
    output logic              rec_valid,
    input  logic              rec_ready,
    output fcs_pkg::fcs_rec_t rec
);
    import fcs_pkg::*;

    logic [7:0]          gen_a_reg, gen_a_next;
    logic [7:0]          gen_b_reg, gen_b_next;
    logic [7:0]          ver_a_reg, ver_a_next;
    logic [7:0]          ver_b_reg, ver_b_next;
    logic [PosWidth-1:0] pos_reg, pos_next;
    logic [7:0]          len_reg, len_next;
    logic                accept;
    logic                in_body;
    logic                in_cksum;

    // Stall only when the queue cannot take a record
    assign byte_ready = rec_ready;
    assign accept     = byte_valid && byte_ready;

    // Next position, length and sums for the incoming byte
    always_comb
    begin
        pos_next = (pos_reg == PosWidth'(PosCap)) ? pos_reg : pos_reg + 1'b1;
        len_next = (len_reg == 8'(ModBase - 1)) ? 8'd0 : len_reg + 1'b1;
        in_body  = pos_next > PosWidth'(AgeBytes);
        in_cksum = (pos_next == PosWidth'(CksumPosHi)) ||
                   (pos_next == PosWidth'(CksumPosLo));

        gen_a_next = gen_a_reg;
        gen_b_next = gen_b_reg;
        ver_a_next = ver_a_reg;
        ver_b_next = ver_b_reg;
        if (in_body)
        begin
            if (!in_cksum)
                gen_a_next = add_mod255(gen_a_reg, byte_data);
            gen_b_next = add_mod255(gen_b_reg, gen_a_next);
            ver_a_next = add_mod255(ver_a_reg, byte_data);
            ver_b_next = add_mod255(ver_b_reg, ver_a_next);
        end
    end

    // Post the finished sums on the last byte
    assign rec_valid = accept && byte_last;
    assign rec.gen_a  = gen_a_next;
    assign rec.gen_b  = gen_b_next;
    assign rec.length = len_next;
    assign rec.ok     = (ver_a_next == 8'd0) && (ver_b_next == 8'd0);

    // Advance on each transaction, clear after the last byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gen_a_reg <= '0;
            gen_b_reg <= '0;
            ver_a_reg <= '0;
            ver_b_reg <= '0;
            pos_reg   <= '0;
            len_reg   <= '0;
        end
        else if (accept)
        begin
            if (byte_last)
            begin
                gen_a_reg <= '0;
                gen_b_reg <= '0;
                ver_a_reg <= '0;
                ver_b_reg <= '0;
                pos_reg   <= '0;
                len_reg   <= '0;
            end
            else
            begin
                gen_a_reg <= gen_a_next;
                gen_b_reg <= gen_b_next;
                ver_a_reg <= ver_a_next;
                ver_b_reg <= ver_b_next;
                pos_reg   <= pos_next;
                len_reg   <= len_next;
            end
        end
    end

endmodule

// ----- hw/rtl/fcs_queue.sv -----
// ----------------------------------------------------------------------------
// fcs_queue
// Small FIFO of finished-advertisement records between front and back.
// ----------------------------------------------------------------------------
module fcs_queue
#(
    parameter int unsigned DEPTH = 4
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push_valid,
    output logic              push_ready,
    input  fcs_pkg::fcs_rec_t push_rec,
    output logic              pop_valid,
    input  logic              pop_ready,
    output fcs_pkg::fcs_rec_t pop_rec
);
    import fcs_pkg::*;

    localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CntW = $clog2(DEPTH + 1);

    fcs_rec_t            mem_reg [DEPTH];
    logic [PtrW-1:0]     wr_ptr_reg, rd_ptr_reg;
    logic [CntW-1:0]     count_reg;
    logic                do_push, do_pop;

    assign push_ready = count_reg != CntW'(DEPTH);
    assign pop_valid  = count_reg != '0;
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;
    assign pop_rec    = mem_reg[rd_ptr_reg];

    // Store records
    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= push_rec;
    end

    // Advance pointers and occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= (wr_ptr_reg == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            if (do_pop)
                rd_ptr_reg <= (rd_ptr_reg == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            if (do_push && !do_pop)
                count_reg <= count_reg + 1'b1;
            else if (do_pop && !do_push)
                count_reg <= count_reg - 1'b1;
        end
    end

endmodule

// ----- hw/rtl/fcs_back.sv -----
// ----------------------------------------------------------------------------
// fcs_back
// Checksum finisher: multiplies the length terms by C0, reduces modulo 255,
// and holds the result in an output register.
// ----------------------------------------------------------------------------
module fcs_back
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              rec_valid,
    output logic              rec_ready,
    input  fcs_pkg::fcs_rec_t rec,
    output logic              res_valid,
    input  logic              res_ready,
    output logic [15:0]       res_value,
    output logic              res_ok
);
    import fcs_pkg::*;

    logic [7:0]  term_x, term_y;
    logic        s1_ready, out_ready;
    logic        s1_valid_reg;
    logic [15:0] prod_x_reg, prod_y_reg;
    logic [7:0]  gen_b_reg;
    logic        ok_s1_reg;
    logic [7:0]  cks_x, cks_y;
    logic        out_valid_reg;
    logic [15:0] out_value_reg;
    logic        out_ok_reg;

    assign out_ready = !out_valid_reg || res_ready;
    assign s1_ready  = !s1_valid_reg || out_ready;
    assign rec_ready = s1_ready;

    // (L - 17) and (L - 16) modulo 255
    always_comb
    begin
        term_x = (rec.length >= 8'(LenOffsetX)) ? rec.length - 8'(LenOffsetX)
                                                : rec.length + 8'(ModBase - LenOffsetX);
        term_y = (rec.length >= 8'(LenOffsetY)) ? rec.length - 8'(LenOffsetY)
                                                : rec.length + 8'(ModBase - LenOffsetY);
    end

    // Stage 1: register the two products
    always_ff @(posedge clk)
    begin
        if (s1_ready && rec_valid)
        begin
            prod_x_reg <= 16'(term_x) * 16'(rec.gen_a);
            prod_y_reg <= 16'(term_y) * 16'(rec.gen_a);
            gen_b_reg  <= rec.gen_b;
            ok_s1_reg  <= rec.ok;
        end
    end

    // Stage 2: X = t1*C0 - C1, Y = C1 - t2*C0, all modulo 255
    always_comb
    begin
        cks_x = add_mod255(fold_mod255(prod_x_reg), 8'(ModBase) - gen_b_reg);
        cks_y = add_mod255(gen_b_reg, 8'(ModBase) - fold_mod255(prod_y_reg));
    end

    always_ff @(posedge clk)
    begin
        if (out_ready && s1_valid_reg)
        begin
            out_value_reg <= {cks_x, cks_y};
            out_ok_reg    <= ok_s1_reg;
        end
    end

    // Pipeline valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_ready)
                s1_valid_reg <= rec_valid;
            if (out_ready)
                out_valid_reg <= s1_valid_reg;
        end
    end

    assign res_valid = out_valid_reg;
    assign res_value = out_value_reg;
    assign res_ok    = out_ok_reg;

endmodule

// ----- hw/rtl/lsa_fletcher_checksum.sv -----
// ----------------------------------------------------------------------------
// lsa_fletcher_checksum
// OSPF LSA Fletcher checksum engine: generates the checksum of a serialized
// advertisement and checks the stored one.
//
//   Channel   Dir  tdata (low bit up)         tlast       tuser
//   s_axis    in   [7:0]  data byte           last byte   -
//   m_axis    out  [15:0] checksum (X hi, Y lo) -         [0] checksum ok
//
// One byte is taken every cycle while the queue has room; the
// accumulator updates in the same cycle. The last byte's record is
// written into the queue, then passes through the product stage and
// the output register before the result is offered on m_axis.
// A queue of QUEUE_DEPTH records lets bytes keep flowing while results stall;
// s_axis_tready drops only when the queue is full.
// rst_n clears the sums, counters, queue and output valid asynchronously.
// ----------------------------------------------------------------------------
module lsa_fletcher_checksum
#(
    parameter int unsigned QUEUE_DEPTH = 4
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [15:0] checksum_value
    output logic        m_axis_tuser    // [0] checksum_ok
);
    import fcs_pkg::*;

    logic     push_valid, push_ready;
    fcs_rec_t push_rec;
    logic     pop_valid, pop_ready;
    fcs_rec_t pop_rec;

    // Front: accumulate bytes
    fcs_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (s_axis_tvalid),
        .byte_ready (s_axis_tready),
        .byte_data  (s_axis_tdata),
        .byte_last  (s_axis_tlast),
        .rec_valid  (push_valid),
        .rec_ready  (push_ready),
        .rec        (push_rec)
    );

    // Queue of finished advertisements
    fcs_queue #(.DEPTH(QUEUE_DEPTH)) u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_rec   (push_rec),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_rec    (pop_rec)
    );

    // Back: finish checksum
    fcs_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .rec_valid  (pop_valid),
        .rec_ready  (pop_ready),
        .rec        (pop_rec),
        .res_valid  (m_axis_tvalid),
        .res_ready  (m_axis_tready),
        .res_value  (m_axis_tdata),
        .res_ok     (m_axis_tuser)
    );

endmodule

// ----- hw/rtl/fcs_checker.sv -----
// ----------------------------------------------------------------------------
// fcs_checker
// Port-level checks for the LSA Fletcher checksum engine, bound to the top.
// ----------------------------------------------------------------------------
module fcs_checker
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,
    input  logic        s_axis_tlast,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [15:0] m_axis_tdata,
    input  logic        m_axis_tuser
);

    // Output valid is low on the edge after reset is seen
    a_reset_idle: assert property (@(posedge clk) !rst_n |=> !m_axis_tvalid)
        else $error("result valid during reset");

    // A stalled result stays offered
    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result dropped while stalled");

    // A stalled result keeps its payload
    a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result payload changed while stalled");

    // Checksum bytes are reduced residues, never 255
    a_residue: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[15:8] != 8'hFF) && (m_axis_tdata[7:0] != 8'hFF))
        else $error("checksum byte not reduced modulo 255");

endmodule

bind lsa_fletcher_checksum fcs_checker u_fcs_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
